/* src/tpcd_pkg.sv */
// Shared types, codes and helpers of the telemetry point change detector.
`timescale 1ns / 1ps
package tpcd_pkg;

  localparam int unsigned KeyW   = 42;
  localparam int unsigned ValW   = 48;
  localparam int unsigned DeltaW = 49;
  localparam int unsigned QualW  = 8;
  localparam int unsigned AbsW   = 47;
  localparam int unsigned RateW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [31:0] HashMul = 32'd2654435761;
  localparam logic [AbsW-1:0]  AbsReset  = 47'd65536000;
  localparam logic [RateW-1:0] RateReset = 16'd512;

  localparam logic [1:0] CmdMeasured = 2'd2;
  localparam logic [1:0] CmdEnergy   = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgAbsThreshold  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRateThreshold = 2'd1;

  typedef enum logic [1:0] {
    StUpdated  = 2'd0,
    StInserted = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_SPIKE
  } state_e;

  // One way of a bucket as it sits in the table.
  typedef struct packed {
    logic                    valid;
    logic [KeyW-1:0]         key;
    logic signed [ValW-1:0]  value;
    logic [QualW-1:0]        quality;
  } way_t;

  // Multiplicative hash on 32 bits, folded once; the caller keeps the low bits.
  function automatic logic [31:0] hash32(logic [1:0] cmd, logic [15:0] ca, logic [23:0] oa);
    logic [31:0] prod;
    logic [31:0] h;
    prod = (cmd[0] ? HashMul : 32'd0) + (cmd[1] ? {HashMul[30:0], 1'b0} : 32'd0);
    h = prod ^ {ca, 16'd0} ^ {8'd0, oa};
    return h ^ {16'd0, h[31:16]};
  endfunction

endpackage

/* src/tpcd_bucket_ram.sv */
// Bucket table: one row per bucket holding all ways, one read and one write port.
`timescale 1ns / 1ps
module tpcd_bucket_ram
  import tpcd_pkg::*;
#(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4,
  localparam int unsigned BW     = $clog2(BUCKETS)
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [BW-1:0]         rd_addr_i,
  output way_t [WAYS-1:0]       rd_row_o,
  input  logic                  wr_en_i,
  input  logic [BW-1:0]         wr_addr_i,
  input  way_t [WAYS-1:0]       wr_row_i
);

  way_t [WAYS-1:0] mem_q [BUCKETS];
  way_t [WAYS-1:0] rd_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

/* src/telemetry_point_change_detector.sv */
// Top level of the telemetry point change detector.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | sink      | in_valid_i / in_stall_o    | cmd, common/object address, value, quality
//  out     | source    | out_valid_o / out_stall_i  | status, changed, spike, previous, delta
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | register index, write data
//
// Each update passes through these steps in order: accept and bucket row read, way
// match with the row written back and the delta formed, change decision and ratio
// partial products, then the spike compare loading the output register.
// Because of the read-modify-write of one bucket row, the next update is taken only
// once the previous one has left the spike stage.
// After reset a clearing pass writes every bucket row, during which in_stall_o is
// high; configuration writes are taken at any time.
// A result waiting in the output register does not block the next transfer in; the
// block holds its finished result only when the output register is still occupied.
// BUCKETS must be a power of two; the bucket is the low bits of the folded hash.
module telemetry_point_change_detector
  import tpcd_pkg::*;
#(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                in_cmd_i,
  input  logic [15:0]               in_common_address_i,
  input  logic [23:0]               in_object_address_i,
  input  logic signed [ValW-1:0]    in_sample_value_i,
  input  logic [QualW-1:0]          in_quality_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                out_status_o,
  output logic                      out_changed_o,
  output logic                      out_spike_o,
  output logic signed [ValW-1:0]    out_previous_value_o,
  output logic signed [DeltaW-1:0]  out_delta_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [AbsW-1:0]           cfg_data_i
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  state_e state_q, state_d;

  // Configuration registers.
  logic [AbsW-1:0]  abs_thr_q;
  logic [RateW-1:0] rate_thr_q;

  // Item registers.
  logic [1:0]             cmd_q;
  logic [15:0]            ca_q;
  logic [23:0]            oa_q;
  logic signed [ValW-1:0] val_q;
  logic [QualW-1:0]       qual_q;
  logic [BW-1:0]          bucket_q;
  logic [BW-1:0]          clr_q;

  // Lookup results.
  status_e                  status_q;
  logic                     found_q;
  logic signed [ValW-1:0]   prev_q;
  logic signed [DeltaW-1:0] delta_q;
  logic                     qdiff_q;

  // Check stage results.
  logic        changed_q;
  logic        abs_hit_q;
  logic        prev_pos_q;
  logic [39:0] pa_lo_q, pa_hi_q, pb_lo_q, pb_hi_q;

  // Output register.
  logic                     out_valid_q;
  status_e                  out_status_q;
  logic                     out_changed_q;
  logic                     out_spike_q;
  logic signed [ValW-1:0]   out_prev_q;
  logic signed [DeltaW-1:0] out_delta_q;

  logic in_xfer, load_out;
  logic [31:0] hash;

  // Table port signals.
  logic            rd_en;
  logic [BW-1:0]   rd_addr;
  way_t [WAYS-1:0] rd_row;
  logic            wr_en;
  logic [BW-1:0]   wr_addr;
  way_t [WAYS-1:0] wr_row;

  tpcd_bucket_ram #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_row_i  (wr_row)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign hash = hash32(in_cmd_i, in_common_address_i, in_object_address_i);
  assign rd_en   = in_xfer;
  assign rd_addr = hash[BW-1:0];

  // Way search: the first valid way whose key matches, else the lowest free way.
  logic [KeyW-1:0] key;
  logic            hit, free;
  logic [WW-1:0]   hit_way, free_way, slot;
  assign key = {cmd_q, ca_q, oa_q};

  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_way = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row[w].valid && rd_row[w].key == key) begin
        hit = 1'b1;
        hit_way = WW'(w);
      end
      if (!rd_row[w].valid) begin
        free = 1'b1;
        free_way = WW'(w);
      end
    end
    slot = hit ? hit_way : free_way;
  end

  // Write port: clearing pass rows, or the updated bucket row after the search.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = bucket_q;
    wr_row = rd_row;
    if (state_q == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_q;
      wr_row = '0;
    end else if (state_q == S_LOOKUP && (hit || free)) begin
      wr_en = 1'b1;
      wr_row[slot] = '{valid: 1'b1, key: key, value: val_q, quality: qual_q};
    end
  end

  assign load_out = (state_q == S_SPIKE) && (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_q == BW'(BUCKETS - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_xfer) state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_CHECK;
      S_CHECK:  state_d = S_SPIKE;
      S_SPIKE:  if (load_out) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      abs_thr_q  <= AbsReset;
      rate_thr_q <= RateReset;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgAbsThreshold) begin
          abs_thr_q <= cfg_data_i;
        end else if (cfg_index_i == CfgRateThreshold) begin
          rate_thr_q <= cfg_data_i[RateW-1:0];
        end
      end
    end
  end

  // Capture the item while its bucket row is read.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= in_cmd_i;
      ca_q     <= in_common_address_i;
      oa_q     <= in_object_address_i;
      val_q    <= in_sample_value_i;
      qual_q   <= in_quality_i;
      bucket_q <= hash[BW-1:0];
    end
  end

  // Lookup stage: hit flag, status, and the previous value, delta and quality difference of a hit.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOKUP) begin
      found_q <= hit;
      status_q <= hit ? StUpdated : (free ? StInserted : StFull);
      prev_q  <= hit ? rd_row[hit_way].value : '0;
      delta_q <= hit ? ({val_q[ValW-1], val_q} - {rd_row[hit_way].value[ValW-1],
                        rd_row[hit_way].value}) : '0;
      qdiff_q <= hit && (rd_row[hit_way].quality != qual_q);
    end
  end

  // Check stage: change decision, absolute threshold, and the ratio products split
  // in 24-bit halves so each multiplier stays at 16 by 24 bits.
  logic [DeltaW-1:0] mag;
  logic [ValW-1:0]   vp1;
  assign mag = delta_q[DeltaW-1] ? DeltaW'(-delta_q) : DeltaW'(delta_q);
  assign vp1 = ValW'(val_q) + ValW'(1);

  always_ff @(posedge clk_i) begin
    if (state_q == S_CHECK) begin
      if (status_q == StInserted) begin
        changed_q <= 1'b1;
      end else if (!found_q) begin
        changed_q <= 1'b0;
      end else if (cmd_q == CmdMeasured) begin
        changed_q <= (mag > DeltaW'(1)) || qdiff_q;
      end else begin
        changed_q <= (delta_q != '0) || qdiff_q;
      end
      abs_hit_q  <= mag >= DeltaW'(abs_thr_q);
      prev_pos_q <= !prev_q[ValW-1] && (prev_q[ValW-2:0] > (ValW-1)'(1));
      pa_lo_q <= 40'(rate_thr_q) * 40'(prev_q[23:0]);
      pa_hi_q <= 40'(rate_thr_q) * 40'(prev_q[47:24]);
      pb_lo_q <= 40'(rate_thr_q) * 40'(vp1[23:0]);
      pb_hi_q <= 40'(rate_thr_q) * 40'(vp1[47:24]);
    end
  end

  // Spike stage: both ratio directions against the assembled products.
  logic [63:0] rt_prev, rt_vp1, val_sh, prev_sh;
  logic        val_neg, spike;
  assign rt_prev = {pa_hi_q, 24'd0} + {24'd0, pa_lo_q};
  assign rt_vp1  = {pb_hi_q, 24'd0} + {24'd0, pb_lo_q};
  assign val_neg = val_q[ValW-1];
  assign val_sh  = {9'd0, val_q[ValW-2:0], 8'd0};
  assign prev_sh = {9'd0, prev_q[ValW-2:0], 8'd0};
  assign spike = (cmd_q == CmdEnergy) && found_q &&
                 (abs_hit_q || (prev_pos_q && !val_neg &&
                  ((val_sh >= rt_prev) || (prev_sh >= rt_vp1))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q  <= status_q;
      out_changed_q <= changed_q;
      out_spike_q   <= spike;
      out_prev_q    <= prev_q;
      out_delta_q   <= delta_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_o         = out_status_q;
  assign out_changed_o        = out_changed_q;
  assign out_spike_o          = out_spike_q;
  assign out_previous_value_o = out_prev_q;
  assign out_delta_o          = out_delta_q;

  // A new result appears only as the spike stage finishes.
  a_out_from_spike: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_SPIKE))
    else $error("result appeared without a finished item");

  // A dropped update carries no change, spike or delta.
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == StFull) |->
      (!out_changed_o && !out_spike_o && out_delta_o == '0))
    else $error("dropped update reports data");

  // A spike is only reported against an existing entry.
  a_spike_existing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_spike_o) |-> (out_status_o == StUpdated))
    else $error("spike on a new or dropped entry");

  // Every item starts from an idle block, never during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOKUP) |-> $past(state_q == S_IDLE))
    else $error("lookup entered without an accepted item");

endmodule
